/* sv/xorshift64star_random_range_defines.svh */
// Assertion macros for the asserting file of the block.
`ifndef XORSHIFT64STAR_RANDOM_RANGE_DEFINES_SVH
`define XORSHIFT64STAR_RANDOM_RANGE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define XSRR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xsrr same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define XSRR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xsrr next-cycle check failed");
`else
`define XSRR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define XSRR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

/* sv/xsrr_pkg.sv */
package xsrr_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned BOUND_W = 32;
    localparam int unsigned SPAN_W  = BOUND_W + 1;
    localparam int unsigned FRAC_W  = 53;
    localparam int unsigned FRAC_LSB = STATE_W - FRAC_W;
    localparam int unsigned HALF_W  = STATE_W / 2;

    localparam int unsigned IN_TDATA_W  = 2 * BOUND_W;
    localparam int unsigned OUT_FIELD_W = FRAC_W + BOUND_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [STATE_W-1:0] SEED_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [STATE_W-1:0] OUT_MULT    = 64'h2545_f491_4f6c_dd1d;

    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;

    localparam int unsigned DIV_STEPS = STATE_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // Partial-product selection for the 64x64 low-half multiply.
    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_HL = 2'd1,
        MUL_LH = 2'd2
    } xsrr_mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } xsrr_state_t;

    typedef struct packed {
        logic          capture;
        logic          advance;
        logic          mul_en;
        xsrr_mul_sel_t mul_sel;
        logic          div_en;
        logic          load_out;
    } xsrr_cmd_t;

    typedef struct packed {
        logic mode;
        logic bad_range;
    } xsrr_sts_t;

endpackage

/* sv/xsrr_dp.sv */
module xsrr_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  xsrr_pkg::xsrr_cmd_t              cmd,
    output xsrr_pkg::xsrr_sts_t              sts,
    input  logic                             in_mode,
    input  logic [xsrr_pkg::IN_TDATA_W-1:0]  in_data,   // low_bound, high_bound
    output logic [xsrr_pkg::OUT_TDATA_W-1:0] out_data,  // fraction, integer_value, pad
    output logic                             out_err
);
    import xsrr_pkg::*;

    logic [STATE_W-1:0] gen_reg, gen_next;
    logic [STATE_W-1:0] acc_reg;
    logic [SPAN_W-1:0]  rem_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [BOUND_W-1:0] lo_reg;
    logic               mode_reg;
    logic               bad_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [BOUND_W-1:0] ival_reg;
    logic               err_reg;

    logic [STATE_W-1:0] seed, x1, x2;
    logic [HALF_W-1:0]  op_a, op_b;
    logic [STATE_W-1:0] prod;
    logic [SPAN_W:0]    trial, shifted;
    logic [BOUND_W-1:0] in_lo, in_hi;
    logic [SPAN_W-1:0]  in_span;

    assign in_lo = in_data[BOUND_W-1:0];
    assign in_hi = in_data[2*BOUND_W-1:BOUND_W];
    // hi - lo + 1 at 33 bits; valid whenever hi >= lo
    assign in_span = {in_hi[BOUND_W-1], in_hi} - {in_lo[BOUND_W-1], in_lo} + SPAN_W'(1);

    // xorshift64* state step
    always_comb begin
        seed     = (gen_reg == '0) ? SEED_GOLDEN : gen_reg;
        x1       = seed ^ (seed >> SHIFT_A);
        x2       = x1 ^ (x1 << SHIFT_B);
        gen_next = x2 ^ (x2 >> SHIFT_C);
    end

    // one 32x32 partial product per cycle; cross terms only need their low half
    always_comb begin
        op_a = (cmd.mul_sel == MUL_HL) ? gen_reg[STATE_W-1:HALF_W] : gen_reg[HALF_W-1:0];
        op_b = (cmd.mul_sel == MUL_LH) ? OUT_MULT[STATE_W-1:HALF_W] : OUT_MULT[HALF_W-1:0];
        prod = op_a * op_b;
    end

    // restoring remainder step, dividend bits shifted out of acc
    always_comb begin
        shifted = {rem_reg, acc_reg[STATE_W-1]};
        trial   = shifted - {1'b0, span_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= '0;
        end else if (cmd.advance) begin
            gen_reg <= gen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= in_mode;
            lo_reg   <= in_lo;
            span_reg <= in_span;
            bad_reg  <= $signed(in_hi) < $signed(in_lo);
            rem_reg  <= '0;
        end else if (cmd.div_en) begin
            if (!trial[SPAN_W]) begin
                rem_reg <= trial[SPAN_W-1:0];
            end else begin
                rem_reg <= shifted[SPAN_W-1:0];
            end
        end
        if (cmd.mul_en) begin
            if (cmd.mul_sel == MUL_LL) begin
                acc_reg <= prod;
            end else begin
                acc_reg <= acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end else if (cmd.div_en) begin
            acc_reg <= acc_reg << 1;
        end
        if (cmd.load_out) begin
            priority if (mode_reg && bad_reg) begin
                frac_reg <= '0;
                ival_reg <= '0;
                err_reg  <= 1'b1;
            end else if (mode_reg) begin
                frac_reg <= '0;
                ival_reg <= lo_reg + rem_reg[BOUND_W-1:0];
                err_reg  <= 1'b0;
            end else begin
                frac_reg <= acc_reg[STATE_W-1:FRAC_LSB];
                ival_reg <= '0;
                err_reg  <= 1'b0;
            end
        end
    end

    assign sts.mode      = mode_reg;
    assign sts.bad_range = bad_reg;
    assign out_data      = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, ival_reg, frac_reg};
    assign out_err       = err_reg;

endmodule

/* sv/xsrr_ctrl.sv */
module xsrr_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  xsrr_pkg::xsrr_sts_t      sts,
    output xsrr_pkg::xsrr_cmd_t      cmd,
    output xsrr_pkg::xsrr_state_t    state
);
    import xsrr_pkg::*;

    xsrr_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.mode && sts.bad_range) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = xsrr_mul_sel_t'(cnt_reg[1:0]);
                if (cnt_reg[1:0] == MUL_LH) begin
                    cnt_next   = '0;
                    state_next = sts.mode ? ST_DIV : ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || out_ready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

/* sv/xorshift64star_random_range.sv */
// xorshift64* random source with a fraction mode and a bounded-integer mode.
// Input stream (s_axis): one transfer is one request. tuser carries the mode
// (0 = fraction, 1 = integer); tdata carries low_bound in [31:0] and
// high_bound in [63:32], both signed.
// Output stream (m_axis): one transfer per request. tdata carries fraction
// in [52:0] and integer_value in [84:53], upper bits zero; tuser carries
// range_error. In integer mode a reversed range returns the error flag with
// zero data and leaves the generator state untouched.
// A request passes through check, multiply and, in integer mode, remainder
// states; a reversed integer range goes from check straight to the output.
// The 64-step restoring remainder unit serves integer mode, and the multiply
// runs on one shared 32x32 multiplier. One request is in work at a time;
// the next is taken once the result sits in the output register.
// Reset clears the generator state to zero (the golden-ratio seed is used on
// first advance) and empties the output register. When the receiver stalls,
// the result holds in the output register; one further request may complete
// its work and then waits until that register drains.
`include "xorshift64star_random_range_defines.svh"

module xorshift64star_random_range (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [xsrr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // low_bound, high_bound
    input  logic                             s_axis_tuser,  // mode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [xsrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // fraction, integer_value, pad
    output logic                             m_axis_tuser   // range_error
);
    import xsrr_pkg::*;

    xsrr_cmd_t   cmd;
    xsrr_sts_t   sts;
    xsrr_state_t fsm_state;

    // sequencer: accept, check, multiply, remainder, hand off
    xsrr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd),
        .state     (fsm_state)
    );

    // generator state, multiplier, remainder unit and output register
    xsrr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_mode  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_err  (m_axis_tuser)
    );

    // input is only taken while the sequencer is idle
    `XSRR_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_axis_tready, fsm_state == ST_IDLE)
    // an error result carries zero data
    `XSRR_ASSERT_IMP(a_err_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == '0)
    // the two result fields are never both nonzero
    `XSRR_ASSERT_IMP(a_one_field, aclk, aresetn,
        m_axis_tvalid && (m_axis_tdata[FRAC_W+BOUND_W-1:FRAC_W] != '0),
        m_axis_tdata[FRAC_W-1:0] == '0)
    // an accepted request never yields a result on the next edge
    `XSRR_ASSERT_NXT(a_no_early, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, fsm_state == ST_CHECK)

endmodule
